// ===== sv/whp_pkg.sv =====
// windowed pixel histogram: shared widths, item kinds, register indexes
// and the divider status struct; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package whp_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int SEL_W      = 8;
	localparam int BINS_W     = 9;
	localparam int SPAN_W     = BINS_W;
	localparam int PH_W       = 12;
	localparam int QUOT_W     = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int OUT_CNT_W  = 32;
	// rounded bin numerator 2*v*span + high, and its divisor 2*high
	localparam int BIN_NUM_W  = SAMPLE_W + SPAN_W + 2;
	localparam int BIN_DEN_W  = SAMPLE_W + 1;

	typedef enum logic [1:0] {
		KIND_COUNT = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	localparam logic [CFG_IDX_W-1:0] CFG_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BINS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PLOT  = 3'd4;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ===== sv/windowed_pixel_histogram.sv =====
// windowed pixel histogram top: bins in one ram, items handled one at a time
// a counted sample passes multiply, 12-step divider, ram read and write before the next beat
// a read passes multiply, divider (skipped at zero peak) and output state before its result beat
// a clear beat, and the pass that follows reset, sweep every bin of the ram
// arst_n clears control and the peak and loads the default settings; bins are zeroed by that clearing pass
// depends on whp_pkg, whp_ram, whp_div
`timescale 1ns / 1ps
`default_nettype none

module windowed_pixel_histogram #(
	parameter int NUM_BINS    = 256,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // sample [15:0], bin_select [23:16]
	input  wire logic [1:0]  s_axis_tuser,  // kind [1:0]
	// master side
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [79:0]      m_axis_tdata,  // bin_count [31:0], bar_height [43:32],
	                                        // peak_count [75:44], zero fill [79:76]
	// configuration writes
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int AW     = $clog2(NUM_BINS);
	localparam int CW     = COUNT_WIDTH;
	localparam int PH_W   = whp_pkg::PH_W;
	localparam int QW     = whp_pkg::QUOT_W;
	localparam int SPAN_W = whp_pkg::SPAN_W;
	localparam int SMP_W  = whp_pkg::SAMPLE_W;
	// shared divider widths cover both the bin index and the bar height
	localparam int NUM_W  = (CW + PH_W > whp_pkg::BIN_NUM_W) ? CW + PH_W : whp_pkg::BIN_NUM_W;
	localparam int DEN_W  = (CW > whp_pkg::BIN_DEN_W) ? CW : whp_pkg::BIN_DEN_W;

	// sequencer states, one-hot
	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_CLEAR   = 9'b000000010,
		ST_CNT_MUL = 9'b000000100,
		ST_CNT_DIV = 9'b000001000,
		ST_CNT_RD  = 9'b000010000,
		ST_CNT_WR  = 9'b000100000,
		ST_RD_MUL  = 9'b001000000,
		ST_RD_DIV  = 9'b010000000,
		ST_RD_OUT  = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [SMP_W-1:0]          low_q;
	logic [SMP_W-1:0]          high_q;
	logic [whp_pkg::BINS_W-1:0] bins_q;
	logic                      wide_q;
	logic [PH_W-1:0]           plot_q;

	// per-item working registers
	logic [SMP_W-1:0]  v_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     clr_q;
	logic              sel_ok_q;
	logic              pz_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     peak_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic              start_q;

	// output register
	logic                           m_valid_q;
	logic [whp_pkg::OUT_CNT_W-1:0]  out_cnt_q;
	logic [PH_W-1:0]                out_bar_q;
	logic [whp_pkg::OUT_CNT_W-1:0]  out_peak_q;

	// beat fields
	whp_pkg::kind_t          s_kind;
	logic [SMP_W-1:0]        s_sample;
	logic [whp_pkg::SEL_W-1:0] s_sel;
	logic                    s_acc;

	assign s_kind   = whp_pkg::kind_t'(s_axis_tuser);
	assign s_sample = s_axis_tdata[15:0];
	assign s_sel    = s_axis_tdata[23:16];

	// divider and ram hookup
	whp_pkg::div_stat_t div_stat;
	logic [QW-1:0]      div_quot;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [CW-1:0]      ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [CW-1:0]      ram_rdata;

	// only one item is in flight, so no forwarding is needed around the ram
	assign s_axis_tready = (state_q == ST_IDLE) && !div_stat.busy;
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	// window test on the mode-masked sample
	logic [SMP_W-1:0] v_in;
	logic             in_win;

	assign v_in   = wide_q ? s_sample : {8'h00, s_sample[7:0]};
	assign in_win = (v_in >= low_q) && (v_in <= high_q);

	// bins in use clamped to 1..NUM_BINS, span is that minus one
	logic [whp_pkg::BINS_W-1:0] eff_bins;
	logic [SPAN_W-1:0]          span;

	always_comb begin
		if (bins_q == '0) begin
			eff_bins = whp_pkg::BINS_W'(1);
		end else if (32'(bins_q) > NUM_BINS) begin
			eff_bins = whp_pkg::BINS_W'(NUM_BINS);
		end else begin
			eff_bins = bins_q;
		end
	end

	assign span = SPAN_W'(eff_bins - 1'b1);

	// bin numerator: v*span floored, or (2*v*span + high) / (2*high) rounded
	logic [SMP_W+SPAN_W-1:0] vs_prod;
	logic [NUM_W-1:0]        bin_num;
	logic [DEN_W-1:0]        bin_den;

	assign vs_prod = (SMP_W+SPAN_W)'(v_q) * (SMP_W+SPAN_W)'(span);
	assign bin_num = wide_q ? NUM_W'(vs_prod)
	                        : NUM_W'({vs_prod, 1'b0}) + NUM_W'(high_q);
	assign bin_den = wide_q ? DEN_W'(high_q) : DEN_W'({high_q, 1'b0});

	// bin index from the quotient, clamped to span; a zero high limit goes to bin zero
	logic [SPAN_W-1:0] idx8;

	always_comb begin
		if (high_q == '0) begin
			idx8 = '0;
		end else if (div_quot > QW'(span)) begin
			idx8 = span;
		end else begin
			idx8 = div_quot[SPAN_W-1:0];
		end
	end

	// read path: count of the chosen bin, scaled by plot height
	logic [CW-1:0]      rd_cnt;
	logic [CW+PH_W-1:0] rd_prod;

	assign rd_cnt  = sel_ok_q ? ram_rdata : '0;
	assign rd_prod = (CW+PH_W)'(plot_q) * (CW+PH_W)'(rd_cnt);

	// saturating increment of the bin just read
	logic [CW-1:0] incr;

	assign incr = (ram_rdata == {CW{1'b1}}) ? ram_rdata : ram_rdata + 1'b1;

	// ram port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = incr;
		ram_raddr = idx_q;
		case (state_q)
			ST_IDLE: begin
				ram_raddr = AW'(s_sel);
			end
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_CNT_RD: begin
				ram_raddr = AW'(idx8);
			end
			ST_CNT_WR: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= 16'd0;
			high_q <= 16'd255;
			bins_q <= 9'd256;
			wide_q <= 1'b0;
			plot_q <= 12'd126;
		end else if (cfg_we) begin
			case (cfg_index)
				whp_pkg::CFG_LOW:  low_q  <= cfg_data;
				whp_pkg::CFG_HIGH: high_q <= cfg_data;
				whp_pkg::CFG_BINS: bins_q <= cfg_data[whp_pkg::BINS_W-1:0];
				whp_pkg::CFG_WIDE: wide_q <= cfg_data[0];
				whp_pkg::CFG_PLOT: plot_q <= cfg_data[PH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer; reset starts in the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			peak_q    <= '0;
			start_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			// divider kicks off in the cycle after its operands are latched
			start_q <= (state_q == ST_CNT_MUL) || ((state_q == ST_RD_MUL) && (peak_q != '0));
			if ((state_q == ST_RD_OUT) && (!m_valid_q || m_axis_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						case (s_kind)
							whp_pkg::KIND_COUNT: begin
								// samples outside the window are dropped here
								if (in_win) begin
									state_q <= ST_CNT_MUL;
								end
							end
							whp_pkg::KIND_READ: begin
								state_q <= ST_RD_MUL;
							end
							whp_pkg::KIND_CLEAR: begin
								clr_q   <= '0;
								peak_q  <= '0;
								state_q <= ST_CLEAR;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NUM_BINS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CNT_MUL: begin
					state_q <= ST_CNT_DIV;
				end
				ST_CNT_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_CNT_RD;
					end
				end
				ST_CNT_RD: begin
					state_q <= ST_CNT_WR;
				end
				ST_CNT_WR: begin
					if (incr > peak_q) begin
						peak_q <= incr;
					end
					state_q <= ST_IDLE;
				end
				ST_RD_MUL: begin
					// empty histogram: bar is zero, divider skipped
					if (peak_q == '0) begin
						state_q <= ST_RD_OUT;
					end else begin
						state_q <= ST_RD_DIV;
					end
				end
				ST_RD_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_RD_OUT;
					end
				end
				ST_RD_OUT: begin
					// hold here while the previous result beat still waits
					if (!m_valid_q || m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				v_q      <= v_in;
				sel_ok_q <= (32'(s_sel) < NUM_BINS);
			end
			ST_CNT_MUL: begin
				num_q <= bin_num;
				den_q <= bin_den;
			end
			ST_CNT_RD: begin
				idx_q <= AW'(idx8);
			end
			ST_RD_MUL: begin
				cnt_q <= rd_cnt;
				pz_q  <= (peak_q == '0);
				num_q <= NUM_W'(rd_prod);
				den_q <= DEN_W'(peak_q);
			end
			ST_RD_OUT: begin
				if (!m_valid_q || m_axis_tready) begin
					out_cnt_q  <= whp_pkg::OUT_CNT_W'(cnt_q);
					out_bar_q  <= pz_q ? '0 : div_quot;
					out_peak_q <= whp_pkg::OUT_CNT_W'(peak_q);
				end
			end
			default: begin
			end
		endcase
	end

	whp_ram #(
		.WIDTH (CW),
		.DEPTH (NUM_BINS)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	whp_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.num    (num_q),
		.den    (den_q),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'h0, out_peak_q, out_bar_q, out_cnt_q};

`ifndef ASSERT_OFF
	// divider only finishes while the sequencer waits on it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_CNT_DIV) || (state_q == ST_RD_DIV))
		else $error("divider finished outside a divide state");

	// a result beat only appears from the output state
	a_out_from_rd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_RD_OUT))
		else $error("result beat raised outside the output state");

	// peak never drops except on a clear beat
	a_peak_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_acc && (s_kind == whp_pkg::KIND_CLEAR)) |=> (peak_q >= $past(peak_q)))
		else $error("peak decreased without a clear");
`endif

endmodule

`default_nettype wire

// ===== sv/whp_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module whp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== sv/whp_div.sv =====
// restoring divider, one quotient bit per cycle, fixed quotient width
// depends on whp_pkg (quotient width, status struct)
`timescale 1ns / 1ps
`default_nettype none

module whp_div #(
	parameter int NUM_W = 44,
	parameter int DEN_W = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [NUM_W-1:0]           num,
	input  wire logic [DEN_W-1:0]           den,
	output whp_pkg::div_stat_t              stat,
	output logic [whp_pkg::QUOT_W-1:0]      quot
);

	localparam int QW    = whp_pkg::QUOT_W;
	localparam int REM_W = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;
	localparam int CNT_W = $clog2(QW);

	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] dsh_q;
	logic [QW-1:0]    quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             ge;

	// caller guarantees num < den * 2^QW, so the quotient fits
	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(QW - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= REM_W'(num);
			dsh_q <= REM_W'(den) << (QW - 1);
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[QW-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && (cnt_q == '0);
	assign quot      = quot_q;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// testbench for windowed_pixel_histogram: directed items, random phases under fixed and random
// settings, then a back-to-back stretch, checked beat by beat against an in-bench histogram predictor
// depends on whp_pkg and the windowed_pixel_histogram rtl
`timescale 1ns / 1ps

module tb;

	localparam int NBINS         = 256;
	localparam int SETTLE_CYCLES = 300;     // longer than a clearing sweep
	localparam int CYCLE_LIMIT   = 800000;
	localparam int PHASES        = 14;
	localparam int PHASE_ITEMS   = 110;
	localparam int CALM_ITEMS    = 160;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [whp_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
	localparam logic [31:0] COUNT_TOP = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [31:0] count;
		logic [11:0] bar;
		logic [31:0] peak;
	} bin_report_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // sample [15:0], bin_select [23:16]
	logic [1:0]  s_axis_tuser;   // kind [1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;   // bin_count [31:0], bar_height [43:32], peak_count [75:44]
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	windowed_pixel_histogram dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// predicted histogram and settings
	logic [31:0] hist [NBINS];
	logic [31:0] hist_peak;
	logic [15:0] lo_lim;
	logic [15:0] hi_lim;
	logic [8:0]  bins_cfg;
	logic        wide;
	logic [11:0] plot_ht;

	bin_report_t pending_reads[$];
	int          mismatches;
	int          cycle_count;
	bit          gaps_on;
	bit          stalls_on;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// output side: random stall bursts
	initial begin
		m_axis_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (stalls_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready = 1'b0;
				repeat ($urandom_range(0, 4)) @(negedge clk);
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	task automatic report_mismatch(input string what, input longint unsigned want,
			input longint unsigned got);
		mismatches++;
		$display("mismatch at %0t: %s want %0d got %0d", $realtime, what, want, got);
	endtask

	// each result beat against the oldest predicted read
	always @(posedge clk) begin : check_results
		bin_report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_reads.size() == 0) begin
				report_mismatch("result beat with no read waiting", 0, m_axis_tdata[31:0]);
			end else begin
				want = pending_reads.pop_front();
				if (m_axis_tdata[31:0] !== want.count)
					report_mismatch("bin_count", want.count, m_axis_tdata[31:0]);
				if (m_axis_tdata[43:32] !== want.bar)
					report_mismatch("bar_height", want.bar, m_axis_tdata[43:32]);
				if (m_axis_tdata[75:44] !== want.peak)
					report_mismatch("peak_count", want.peak, m_axis_tdata[75:44]);
			end
		end
	end

	function automatic int unsigned eff_bins();
		if (bins_cfg == 0)
			return 1;
		if (bins_cfg > NBINS)
			return NBINS;
		return 32'(bins_cfg);
	endfunction

	// bin index of an in-window value: floor in wide mode, round half up otherwise
	function automatic int unsigned bin_of(input logic [15:0] v);
		longint unsigned vv, hh, span, idx;
		vv   = 64'(v);
		hh   = 64'(hi_lim);
		span = 64'(eff_bins() - 1);
		if (hh == 0)
			idx = 0;
		else if (wide)
			idx = (vv * span) / hh;
		else
			idx = (2 * vv * span + hh) / (2 * hh);
		if (idx > span)
			idx = span;
		return int'(idx);
	endfunction

	task automatic tally_sample(input logic [15:0] raw);
		logic [15:0] v;
		int unsigned idx;
		v = wide ? raw : {8'h00, raw[7:0]};
		if (v < lo_lim || v > hi_lim)
			return;
		idx = bin_of(v);
		if (hist[idx] != COUNT_TOP)
			hist[idx] = hist[idx] + 1;
		if (hist[idx] > hist_peak)
			hist_peak = hist[idx];
	endtask

	task automatic predict_item(input logic [1:0] kind, input logic [15:0] sample,
			input logic [7:0] sel);
		bin_report_t rep;
		longint unsigned scaled;
		case (kind)
			whp_pkg::KIND_COUNT: tally_sample(sample);
			whp_pkg::KIND_CLEAR: begin
				foreach (hist[i])
					hist[i] = '0;
				hist_peak = '0;
			end
			whp_pkg::KIND_READ: begin
				rep.count = hist[sel];
				rep.peak  = hist_peak;
				if (hist_peak == 0) begin
					rep.bar = '0;
				end else begin
					scaled  = (longint'(plot_ht) * longint'(hist[sel])) / longint'(hist_peak);
					rep.bar = scaled[11:0];
				end
				pending_reads.push_back(rep);
			end
			default: ;
		endcase
	endtask

	// one input beat, with an optional idle burst ahead of it
	task automatic send_item(input logic [1:0] kind, input logic [15:0] sample,
			input logic [7:0] sel);
		int gap;
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			s_axis_tvalid = 1'b0;
			s_axis_tdata  = 24'($urandom);
			s_axis_tuser  = 2'($urandom);
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  = {sel, sample};
		s_axis_tuser  = kind;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		predict_item(kind, sample, sel);
	endtask

	// stop sending, let every read come back and any sweep finish
	task automatic drain_and_settle();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_reads.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_reg(input logic [whp_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we    = 1'b0;
		case (idx)
			whp_pkg::CFG_LOW:  lo_lim   = data;
			whp_pkg::CFG_HIGH: hi_lim   = data;
			whp_pkg::CFG_BINS: bins_cfg = data[8:0];
			whp_pkg::CFG_WIDE: wide     = data[0];
			whp_pkg::CFG_PLOT: plot_ht  = data[11:0];
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [15:0] lo, input logic [15:0] hi, input logic [8:0] nb,
			input logic wd, input logic [11:0] ph);
		drain_and_settle();
		set_reg(whp_pkg::CFG_LOW, lo);
		set_reg(whp_pkg::CFG_HIGH, hi);
		set_reg(whp_pkg::CFG_BINS, {7'($urandom), nb});
		set_reg(whp_pkg::CFG_WIDE, {15'($urandom), wd});
		set_reg(whp_pkg::CFG_PLOT, {4'($urandom), ph});
	endtask

	// mostly samples that land inside the window
	function automatic logic [15:0] pick_sample();
		logic [15:0] s;
		int unsigned top;
		s = 16'($urandom);
		if ($urandom_range(0, 9) < 8) begin
			if (wide) begin
				if (lo_lim <= hi_lim)
					s = 16'($urandom_range(hi_lim, lo_lim));
			end else if (lo_lim <= hi_lim && lo_lim <= 255) begin
				top     = (hi_lim > 255) ? 255 : 32'(hi_lim);
				s[7:0]  = 8'($urandom_range(top, lo_lim));
			end
		end
		return s;
	endfunction

	function automatic logic [7:0] pick_sel();
		if ($urandom_range(0, 4) != 0)
			return 8'($urandom_range(eff_bins() - 1, 0));
		return 8'($urandom);
	endfunction

	task automatic random_item();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			send_item(whp_pkg::KIND_COUNT, pick_sample(), 8'($urandom));
		else if (r < 85)
			send_item(whp_pkg::KIND_READ, 16'($urandom), pick_sel());
		else if (r < 91)
			send_item(whp_pkg::KIND_CLEAR, 16'($urandom), 8'($urandom));
		else
			send_item(KIND_UNUSED, 16'($urandom), 8'($urandom));
	endtask

	task automatic test_directed();
		// reset settings: window 0..255, 256 bins, narrow, height 126
		send_item(whp_pkg::KIND_READ, 16'h0000, 8'd0);     // peak zero gives bar zero
		send_item(whp_pkg::KIND_COUNT, 16'h0000, 8'd0);
		send_item(whp_pkg::KIND_COUNT, 16'hAB80, 8'd0);    // upper byte ignored in narrow mode
		send_item(whp_pkg::KIND_COUNT, 16'h00FF, 8'd0);
		send_item(whp_pkg::KIND_COUNT, 16'h00FF, 8'd0);
		send_item(KIND_UNUSED, 16'hFFFF, 8'hFF);
		send_item(whp_pkg::KIND_READ, 16'h0000, 8'd255);
		send_item(whp_pkg::KIND_READ, 16'h0000, 8'd128);
		send_item(whp_pkg::KIND_CLEAR, 16'h0000, 8'd0);
		send_item(whp_pkg::KIND_READ, 16'h0000, 8'd255);
		// rounding tie goes up: 1*2/4 = 0.5 lands in bin 1
		set_all(16'd0, 16'd4, 9'd3, 1'b0, 12'd126);
		send_item(whp_pkg::KIND_COUNT, 16'h0001, 8'd0);
		send_item(whp_pkg::KIND_COUNT, 16'hFF05, 8'd0);    // above the window
		send_item(whp_pkg::KIND_READ, 16'h0000, 8'd1);
		// wide mode, full range, full height
		set_all(16'd0, 16'hFFFF, 9'd256, 1'b1, 12'd4095);
		send_item(whp_pkg::KIND_COUNT, 16'hFFFF, 8'd0);
		send_item(whp_pkg::KIND_COUNT, 16'h8000, 8'd0);
		send_item(whp_pkg::KIND_READ, 16'h0000, 8'd255);
		// fewer bins: bin 255 keeps its count and still sets the peak
		set_all(16'd0, 16'hFFFF, 9'd4, 1'b1, 12'd4095);
		send_item(whp_pkg::KIND_COUNT, 16'hFFFF, 8'd0);
		send_item(whp_pkg::KIND_READ, 16'h0000, 8'd255);
		// zero bins act as one, zero high limit sends zero to bin 0
		set_all(16'd0, 16'd0, 9'd0, 1'b0, 12'd1);
		send_item(whp_pkg::KIND_COUNT, 16'h0100, 8'd0);
		send_item(whp_pkg::KIND_COUNT, 16'h0001, 8'd0);
		send_item(whp_pkg::KIND_READ, 16'h0000, 8'd0);
		// oversized bin count, empty window, zero height
		set_all(16'd100, 16'd50, 9'd511, 1'b0, 12'd0);
		send_item(whp_pkg::KIND_COUNT, 16'd75, 8'd0);
		set_reg(CFG_SPARE, 16'hFFFF);             // index with no register
		send_item(whp_pkg::KIND_READ, 16'h0000, 8'hFF);
		send_item(whp_pkg::KIND_READ, 16'h0000, 8'd0);
	endtask

	task automatic test_random_phases();
		logic [15:0] lo, hi;
		logic [8:0]  nb;
		logic        wd;
		logic [11:0] ph;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					lo = 16'd0; hi = 16'hFFFF; nb = 9'd256; wd = 1'b1; ph = 12'd4095;
				end
				1: begin
					lo = 16'd0; hi = 16'd0; nb = 9'd2; wd = 1'b0; ph = 12'd0;
				end
				2: begin
					lo = 16'd0; hi = 16'd255; nb = 9'd1; wd = 1'b0; ph = 12'd126;
				end
				3: begin
					lo = 16'hFFF0; hi = 16'hFFFF; nb = 9'd511; wd = 1'b1; ph = 12'd1;
				end
				default: begin
					wd = 1'($urandom_range(0, 1));
					hi = wd ? 16'($urandom) : 16'($urandom_range(300, 1));
					if ($urandom_range(0, 9) < 7)
						lo = 16'($urandom_range(hi / 3, 0));
					else
						lo = 16'($urandom);
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4: nb = 9'($urandom_range(16, 1));
						5, 6, 7:       nb = 9'($urandom_range(511, 0));
						default:       nb = 9'd256;
					endcase
					ph = 12'($urandom);
				end
			endcase
			set_all(lo, hi, nb, wd, ph);
			if ($urandom_range(0, 1) == 0)
				send_item(whp_pkg::KIND_CLEAR, 16'($urandom), 8'($urandom));
			repeat (PHASE_ITEMS) random_item();
		end
	endtask

	// closing stretch with no idling on either side
	task automatic test_back_to_back();
		set_all(16'($urandom_range(40, 0)), 16'($urandom_range(255, 120)),
			9'($urandom_range(64, 2)), 1'b0, 12'($urandom));
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		repeat (CALM_ITEMS) random_item();
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		mismatches    = 0;
		cycle_count   = 0;
		gaps_on       = 1'b1;
		stalls_on     = 1'b1;
		foreach (hist[i])
			hist[i] = '0;
		hist_peak = '0;
		lo_lim    = 16'd0;
		hi_lim    = 16'd255;
		bins_cfg  = 9'd256;
		wide      = 1'b0;
		plot_ht   = 12'd126;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		// bins are zeroed by a sweep after reset
		repeat (SETTLE_CYCLES) @(negedge clk);

		test_directed();
		test_random_phases();
		test_back_to_back();

		drain_and_settle();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/whp_pkg.sv
sv/whp_ram.sv
sv/whp_div.sv
sv/windowed_pixel_histogram.sv
bench/tb.sv
